// ===== design/sm83_cpu_execute_core_defines.svh =====
// assertion macros for the cpu core file
`ifndef SM83_CPU_EXECUTE_CORE_DEFINES_SVH
`define SM83_CPU_EXECUTE_CORE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define SM83_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define SM83_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/sm83_pkg.sv =====
// types and constants of the sm83 execute core
`default_nettype none
package sm83_pkg;

    localparam logic [1:0] OPN_WRITE = 2'd0;
    localparam logic [1:0] OPN_READ  = 2'd1;
    localparam logic [1:0] OPN_EXEC  = 2'd2;
    localparam logic [1:0] OPN_NONE  = 2'd3;

    localparam logic [7:0] PREFIX_OP = 8'hCB;
    localparam logic [7:0] OP_DAA    = 8'h27;
    localparam logic [7:0] OP_HALT   = 8'h76;
    localparam logic [7:0] OP_STOP   = 8'h10;
    localparam logic [7:0] OP_NOP    = 8'h00;
    localparam logic [7:0] OP_LD_NN_SP = 8'h08;
    localparam logic [7:0] OP_JR     = 8'h18;
    localparam logic [7:0] OP_JR_NZ  = 8'h20;
    localparam logic [7:0] OP_JR_Z   = 8'h28;
    localparam logic [7:0] OP_JR_NC  = 8'h30;
    localparam logic [7:0] OP_JR_C   = 8'h38;
    localparam logic [7:0] OP_RLCA   = 8'h07;
    localparam logic [7:0] OP_RRCA   = 8'h0F;
    localparam logic [7:0] OP_RLA    = 8'h17;
    localparam logic [7:0] OP_RRA    = 8'h1F;
    localparam logic [7:0] OP_CPL    = 8'h2F;
    localparam logic [7:0] OP_SCF    = 8'h37;
    localparam logic [7:0] OP_CCF    = 8'h3F;
    localparam logic [7:0] OP_ALU_LO = 8'h80;
    localparam logic [7:0] OP_LD_LO  = 8'h40;
    localparam logic [7:0] OP_UNS_LO = 8'hA0;

    localparam logic [2:0] R8_MEM = 3'd6;
    localparam logic [2:0] R8_A   = 3'd7;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RDW,
        ST_OPC,
        ST_IMM1,
        ST_IMM2,
        ST_EXEC,
        ST_WR2,
        ST_DONE
    } t_state;

    typedef enum logic [3:0] {
        ALU_ADD,
        ALU_ADC,
        ALU_SUB,
        ALU_SBC,
        ALU_INC,
        ALU_DEC,
        ALU_RLC,
        ALU_RRC,
        ALU_RL,
        ALU_RR
    } t_alu_op;

    typedef struct packed {
        logic z;
        logic n;
        logic h;
        logic c;
    } t_flags;

endpackage
`default_nettype wire

// ===== design/sm83_alu.sv =====
// 8-bit arithmetic, increment, decrement and accumulator rotate unit
`default_nettype none
module sm83_alu (
    input  sm83_pkg::t_alu_op i_op,
    input  logic [7:0]        i_a,
    input  logic [7:0]        i_b,
    input  sm83_pkg::t_flags  i_flags,
    output logic [7:0]        o_res,
    output sm83_pkg::t_flags  o_flags
);

    logic       cin;
    logic [8:0] sum9;
    logic [4:0] sum5;
    logic [8:0] dif9;
    logic [4:0] dif5;

    always_comb begin
        cin  = ((i_op == sm83_pkg::ALU_ADC) || (i_op == sm83_pkg::ALU_SBC)) & i_flags.c;
        sum9 = {1'b0, i_a} + {1'b0, i_b} + {8'd0, cin};
        sum5 = {1'b0, i_a[3:0]} + {1'b0, i_b[3:0]} + {4'd0, cin};
        dif9 = {1'b0, i_a} - {1'b0, i_b} - {8'd0, cin};
        dif5 = {1'b0, i_a[3:0]} - {1'b0, i_b[3:0]} - {4'd0, cin};
        o_res   = i_a;
        o_flags = i_flags;
        unique case (i_op)
            sm83_pkg::ALU_ADD, sm83_pkg::ALU_ADC: begin
                o_res   = sum9[7:0];
                o_flags = '{z: (sum9[7:0] == 8'd0), n: 1'b0, h: sum5[4], c: sum9[8]};
            end
            sm83_pkg::ALU_SUB, sm83_pkg::ALU_SBC: begin
                o_res   = dif9[7:0];
                o_flags = '{z: (dif9[7:0] == 8'd0), n: 1'b1, h: dif5[4], c: dif9[8]};
            end
            sm83_pkg::ALU_INC: begin
                o_res   = i_a + 8'd1;
                o_flags = '{z: (i_a == 8'hFF), n: 1'b0, h: (i_a[3:0] == 4'hF), c: i_flags.c};
            end
            sm83_pkg::ALU_DEC: begin
                o_res   = i_a - 8'd1;
                o_flags = '{z: (i_a == 8'd1), n: 1'b1, h: (i_a[3:0] == 4'h0), c: i_flags.c};
            end
            sm83_pkg::ALU_RLC: begin
                o_res   = {i_a[6:0], i_a[7]};
                o_flags = '{z: 1'b0, n: 1'b0, h: 1'b0, c: i_a[7]};
            end
            sm83_pkg::ALU_RRC: begin
                o_res   = {i_a[0], i_a[7:1]};
                o_flags = '{z: 1'b0, n: 1'b0, h: 1'b0, c: i_a[0]};
            end
            sm83_pkg::ALU_RL: begin
                o_res   = {i_a[6:0], i_flags.c};
                o_flags = '{z: 1'b0, n: 1'b0, h: 1'b0, c: i_a[7]};
            end
            sm83_pkg::ALU_RR: begin
                o_res   = {i_flags.c, i_a[7:1]};
                o_flags = '{z: 1'b0, n: 1'b0, h: 1'b0, c: i_a[0]};
            end
            default: begin
                o_res   = i_a;
                o_flags = i_flags;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== design/sm83_cpu_execute_core.sv =====
// sm83 style cpu core with its own byte memory, one operation per word
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------------------
//  in      | to core   | i_valid / o_stall  | i_operation, i_address, i_write_data
//  out     | from core | o_valid / i_stall  | o_read_data, registers, flags, counts, marks
//
// memory write word: stored at acceptance, then done; memory read word: read, capture, done
// execute word: opcode fetch, operand bytes, execute, second store of LD (nn),SP, then done
// the single byte memory port (one read, one write a clock) sets these steps
// synchronous active-low reset clears state, cpu registers and output valid; memory holds
// garbage until written; a new word is taken while a result waits in the output register
`default_nettype none
`include "sm83_cpu_execute_core_defines.svh"
module sm83_cpu_execute_core #(
    parameter int ADDR_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_operation,
    input  logic [15:0] i_address,
    input  logic [7:0]  i_write_data,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_read_data,
    output logic [15:0] o_pc_value,
    output logic [7:0]  o_acc_value,
    output logic [7:0]  o_flag_value,
    output logic [15:0] o_pair_bc,
    output logic [15:0] o_pair_de,
    output logic [15:0] o_pair_hl,
    output logic [15:0] o_stack_value,
    output logic [4:0]  o_cycle_count,
    output logic        o_halted_mark,
    output logic        o_stopped_mark,
    output logic        o_unsupported_mark
);

    localparam int MemDepth = 1 << ADDR_BITS;

    sm83_pkg::t_state r_state, n_state;
    logic [15:0] r_pc, n_pc, r_sp, n_sp;
    logic [7:0]  r_a, n_a, r_b, n_b, r_c, n_c, r_d, n_d, r_e, n_e, r_h, n_h, r_l, n_l;
    sm83_pkg::t_flags r_f, n_f;
    logic        r_halt, n_halt, r_stop, n_stop;
    logic [4:0]  r_cyc, n_cyc;
    logic        r_unsup, n_unsup;
    logic [7:0]  r_rd, n_rd;
    logic [ADDR_BITS-1:0] r_wa, n_wa;
    logic [7:0]  r_op, r_lo, r_hi;
    logic [7:0]  r_mem_q;
    logic [7:0]  r_mem [MemDepth];
    logic        r_out_valid;

    logic [7:0]  r_o_rd, r_o_a, r_o_f;
    logic [15:0] r_o_pc, r_o_bc, r_o_de, r_o_hl, r_o_sp;
    logic [4:0]  r_o_cyc;
    logic        r_o_halt, r_o_stop, r_o_unsup;

    logic                 in_acc, out_free;
    logic [ADDR_BITS-1:0] raddr, mw_addr;
    logic                 mw_en;
    logic [7:0]           mw_data;
    sm83_pkg::t_alu_op    alu_op;
    logic [7:0]           alu_a, alu_b, alu_res;
    sm83_pkg::t_flags     alu_f;

    logic        dec_imm1, dec_mrd, dec_unsup;
    logic [15:0] dec_maddr, dec_pair;
    logic        need2;
    logic [15:0] hl, pair_p, imm16;
    logic [16:0] hl_add;
    logic [12:0] hl_add12;
    logic        dst_en, pw_en, ex_unsup, jr_take;
    logic [2:0]  dst_idx, ex_y, ex_z;
    logic [7:0]  dst_val, src8;
    logic [1:0]  pw_idx;
    logic [15:0] pw_val;

    function automatic logic [15:0] f_pair(input logic [1:0] p, input logic [15:0] bc,
                                           input logic [15:0] de, input logic [15:0] hlv,
                                           input logic [15:0] sp);
        logic [15:0] v;
        case (p)
            2'd0:    v = bc;
            2'd1:    v = de;
            2'd2:    v = hlv;
            default: v = sp;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] f_reg8(input logic [2:0] i, input logic [47:0] gr,
                                          input logic [7:0] memv, input logic [7:0] acc);
        logic [7:0] v;
        case (i)
            3'd0:    v = gr[47:40];
            3'd1:    v = gr[39:32];
            3'd2:    v = gr[31:24];
            3'd3:    v = gr[23:16];
            3'd4:    v = gr[15:8];
            3'd5:    v = gr[7:0];
            3'd6:    v = memv;
            default: v = acc;
        endcase
        return v;
    endfunction

    assign in_acc   = i_valid && !o_stall;
    assign out_free = !r_out_valid || !i_stall;
    assign o_stall  = (r_state != sm83_pkg::ST_IDLE);
    assign hl       = {r_h, r_l};
    assign imm16    = {r_hi, r_lo};
    assign pair_p   = f_pair(r_op[5:4], {r_b, r_c}, {r_d, r_e}, hl, r_sp);
    assign dec_pair = f_pair(r_mem_q[5:4], {r_b, r_c}, {r_d, r_e}, hl, r_sp);
    assign hl_add   = {1'b0, hl} + {1'b0, pair_p};
    assign hl_add12 = {1'b0, hl[11:0]} + {1'b0, pair_p[11:0]};
    assign need2    = (r_op < sm83_pkg::OP_LD_LO)
                   && ((r_op[3:0] == 4'h1) || (r_op == sm83_pkg::OP_LD_NN_SP));

    // opcode decode on the fetched byte
    always_comb begin
        dec_unsup = (r_mem_q >= sm83_pkg::OP_UNS_LO) || (r_mem_q == sm83_pkg::OP_DAA);
        dec_imm1  = (r_mem_q == sm83_pkg::PREFIX_OP)
                 || (!dec_unsup && (r_mem_q < sm83_pkg::OP_LD_LO)
                     && ((r_mem_q == sm83_pkg::OP_JR) || (r_mem_q == sm83_pkg::OP_JR_NZ)
                      || (r_mem_q == sm83_pkg::OP_JR_Z) || (r_mem_q == sm83_pkg::OP_JR_NC)
                      || (r_mem_q == sm83_pkg::OP_JR_C) || (r_mem_q[2:0] == 3'd6)
                      || (r_mem_q[3:0] == 4'h1) || (r_mem_q == sm83_pkg::OP_LD_NN_SP)));
        dec_mrd   = 1'b0;
        dec_maddr = hl;
        if (!dec_unsup) begin
            if (r_mem_q >= sm83_pkg::OP_LD_LO) begin
                dec_mrd = (r_mem_q[2:0] == sm83_pkg::R8_MEM);
            end else if ((r_mem_q[3:0] == 4'hA) || (r_mem_q[3:0] == 4'h2)) begin
                dec_mrd   = r_mem_q[3];
                dec_maddr = r_mem_q[5] ? hl : dec_pair;
            end else begin
                dec_mrd = (r_mem_q[5:3] == sm83_pkg::R8_MEM) && (r_mem_q[2:1] == 2'b10);
            end
        end
    end

    sm83_alu u_alu (
        .i_op    (alu_op),
        .i_a     (alu_a),
        .i_b     (alu_b),
        .i_flags (r_f),
        .o_res   (alu_res),
        .o_flags (alu_f)
    );

    always_comb begin
        n_state = r_state;
        n_pc    = r_pc;
        n_sp    = r_sp;
        n_a     = r_a;
        n_f     = r_f;
        n_b     = r_b;
        n_c     = r_c;
        n_d     = r_d;
        n_e     = r_e;
        n_h     = r_h;
        n_l     = r_l;
        n_halt  = r_halt;
        n_stop  = r_stop;
        n_cyc   = r_cyc;
        n_unsup = r_unsup;
        n_rd    = r_rd;
        n_wa    = r_wa;
        raddr   = r_pc[ADDR_BITS-1:0];
        mw_en   = 1'b0;
        mw_addr = r_wa;
        mw_data = r_a;
        ex_y    = r_op[5:3];
        ex_z    = r_op[2:0];
        src8    = f_reg8(ex_z, {r_b, r_c, r_d, r_e, r_h, r_l}, r_mem_q, r_a);
        alu_op  = sm83_pkg::ALU_ADD;
        alu_a   = r_a;
        alu_b   = src8;
        dst_en  = 1'b0;
        dst_idx = ex_y;
        dst_val = src8;
        pw_en   = 1'b0;
        pw_idx  = r_op[5:4];
        pw_val  = imm16;
        ex_unsup = (r_op >= sm83_pkg::OP_UNS_LO) || (r_op == sm83_pkg::OP_DAA);
        jr_take  = 1'b0;
        unique case (r_state)
            sm83_pkg::ST_IDLE: begin
                if (in_acc) begin
                    n_cyc   = 5'd0;
                    n_unsup = 1'b0;
                    n_rd    = 8'd0;
                    case (i_operation)
                        sm83_pkg::OPN_WRITE: begin
                            mw_en   = 1'b1;
                            mw_addr = i_address[ADDR_BITS-1:0];
                            mw_data = i_write_data;
                            n_state = sm83_pkg::ST_DONE;
                        end
                        sm83_pkg::OPN_READ: begin
                            raddr   = i_address[ADDR_BITS-1:0];
                            n_state = sm83_pkg::ST_RDW;
                        end
                        sm83_pkg::OPN_EXEC: begin
                            n_pc    = r_pc + 16'd1;
                            n_state = sm83_pkg::ST_OPC;
                        end
                        default: n_state = sm83_pkg::ST_DONE;
                    endcase
                end
            end
            sm83_pkg::ST_RDW: begin
                n_rd    = r_mem_q;
                n_state = sm83_pkg::ST_DONE;
            end
            sm83_pkg::ST_OPC: begin
                if (dec_imm1) begin
                    n_pc    = r_pc + 16'd1;
                    n_state = sm83_pkg::ST_IMM1;
                end else begin
                    if (dec_mrd) begin
                        raddr = dec_maddr[ADDR_BITS-1:0];
                    end
                    n_state = sm83_pkg::ST_EXEC;
                end
            end
            sm83_pkg::ST_IMM1: begin
                if (need2) begin
                    n_pc    = r_pc + 16'd1;
                    n_state = sm83_pkg::ST_IMM2;
                end else begin
                    n_state = sm83_pkg::ST_EXEC;
                end
            end
            sm83_pkg::ST_IMM2: n_state = sm83_pkg::ST_EXEC;
            sm83_pkg::ST_EXEC: begin
                n_state = sm83_pkg::ST_DONE;
                n_cyc   = 5'd4;
                if (ex_unsup) begin
                    n_unsup = 1'b1;
                end else if (r_op >= sm83_pkg::OP_ALU_LO) begin
                    unique case (r_op[4:3])
                        2'd0: alu_op = sm83_pkg::ALU_ADD;
                        2'd1: alu_op = sm83_pkg::ALU_ADC;
                        2'd2: alu_op = sm83_pkg::ALU_SUB;
                        2'd3: alu_op = sm83_pkg::ALU_SBC;
                        default: alu_op = sm83_pkg::ALU_ADD;
                    endcase
                    n_a = alu_res;
                    n_f = alu_f;
                    if (ex_z == sm83_pkg::R8_MEM) n_cyc = 5'd8;
                end else if (r_op >= sm83_pkg::OP_LD_LO) begin
                    if (r_op == sm83_pkg::OP_HALT) begin
                        n_halt = 1'b1;
                    end else begin
                        dst_en = 1'b1;
                        if ((ex_y == sm83_pkg::R8_MEM) || (ex_z == sm83_pkg::R8_MEM)) begin
                            n_cyc = 5'd8;
                        end
                    end
                end else begin
                    case (r_op)
                        sm83_pkg::OP_NOP: n_cyc = 5'd4;
                        sm83_pkg::OP_RLCA, sm83_pkg::OP_RRCA,
                        sm83_pkg::OP_RLA, sm83_pkg::OP_RRA: begin
                            case (ex_y[1:0])
                                2'd0:    alu_op = sm83_pkg::ALU_RLC;
                                2'd1:    alu_op = sm83_pkg::ALU_RRC;
                                2'd2:    alu_op = sm83_pkg::ALU_RL;
                                default: alu_op = sm83_pkg::ALU_RR;
                            endcase
                            n_a = alu_res;
                            n_f = alu_f;
                        end
                        sm83_pkg::OP_LD_NN_SP: begin
                            mw_en   = 1'b1;
                            mw_addr = imm16[ADDR_BITS-1:0];
                            mw_data = r_sp[7:0];
                            n_wa    = imm16[ADDR_BITS-1:0];
                            n_cyc   = 5'd20;
                            n_state = sm83_pkg::ST_WR2;
                        end
                        sm83_pkg::OP_STOP: n_stop = 1'b1;
                        sm83_pkg::OP_JR, sm83_pkg::OP_JR_NZ, sm83_pkg::OP_JR_Z,
                        sm83_pkg::OP_JR_NC, sm83_pkg::OP_JR_C: begin
                            case (r_op)
                                sm83_pkg::OP_JR_NZ: jr_take = !r_f.z;
                                sm83_pkg::OP_JR_Z:  jr_take = r_f.z;
                                sm83_pkg::OP_JR_NC: jr_take = !r_f.c;
                                sm83_pkg::OP_JR_C:  jr_take = r_f.c;
                                default:            jr_take = 1'b1;
                            endcase
                            n_cyc = 5'd8;
                            if (jr_take) begin
                                n_pc  = r_pc + {{8{r_lo[7]}}, r_lo};
                                n_cyc = 5'd12;
                            end
                        end
                        sm83_pkg::OP_CPL: begin
                            n_a   = ~r_a;
                            n_f.n = 1'b1;
                            n_f.h = 1'b1;
                        end
                        sm83_pkg::OP_SCF: n_f = '{z: r_f.z, n: 1'b0, h: 1'b0, c: 1'b1};
                        sm83_pkg::OP_CCF: n_f = '{z: r_f.z, n: 1'b0, h: 1'b0, c: !r_f.c};
                        default: begin
                            if ((ex_z == 3'd4) || (ex_z == 3'd5)) begin
                                alu_op  = (ex_z == 3'd4) ? sm83_pkg::ALU_INC : sm83_pkg::ALU_DEC;
                                alu_a   = f_reg8(ex_y, {r_b, r_c, r_d, r_e, r_h, r_l},
                                                 r_mem_q, r_a);
                                dst_en  = 1'b1;
                                dst_val = alu_res;
                                n_f     = alu_f;
                                n_cyc   = (ex_y == sm83_pkg::R8_MEM) ? 5'd12 : 5'd4;
                            end else if (ex_z == 3'd6) begin
                                dst_en  = 1'b1;
                                dst_val = r_lo;
                                n_cyc   = (ex_y == sm83_pkg::R8_MEM) ? 5'd12 : 5'd8;
                            end else begin
                                n_cyc = 5'd8;
                                case (r_op[3:0])
                                    4'h1: begin
                                        pw_en = 1'b1;
                                        n_cyc = 5'd12;
                                    end
                                    4'h2, 4'hA: begin
                                        if (r_op[3]) begin
                                            n_a = r_mem_q;
                                        end else begin
                                            mw_en   = 1'b1;
                                            mw_addr = r_op[5] ? hl[ADDR_BITS-1:0]
                                                              : pair_p[ADDR_BITS-1:0];
                                            mw_data = r_a;
                                        end
                                        if (r_op[5]) begin
                                            pw_en  = 1'b1;
                                            pw_idx = 2'd2;
                                            pw_val = r_op[4] ? (hl - 16'd1) : (hl + 16'd1);
                                        end
                                    end
                                    4'h3: begin
                                        pw_en  = 1'b1;
                                        pw_val = pair_p + 16'd1;
                                    end
                                    4'hB: begin
                                        pw_en  = 1'b1;
                                        pw_val = pair_p - 16'd1;
                                    end
                                    4'h9: begin
                                        pw_en  = 1'b1;
                                        pw_idx = 2'd2;
                                        pw_val = hl_add[15:0];
                                        n_f    = '{z: r_f.z, n: 1'b0, h: hl_add12[12],
                                                   c: hl_add[16]};
                                    end
                                    default: begin
                                        n_unsup = 1'b1;
                                        n_cyc   = 5'd4;
                                    end
                                endcase
                            end
                        end
                    endcase
                end
                if (dst_en) begin
                    case (dst_idx)
                        3'd0: n_b = dst_val;
                        3'd1: n_c = dst_val;
                        3'd2: n_d = dst_val;
                        3'd3: n_e = dst_val;
                        3'd4: n_h = dst_val;
                        3'd5: n_l = dst_val;
                        sm83_pkg::R8_MEM: begin
                            mw_en   = 1'b1;
                            mw_addr = hl[ADDR_BITS-1:0];
                            mw_data = dst_val;
                        end
                        default: n_a = dst_val;
                    endcase
                end
                if (pw_en) begin
                    case (pw_idx)
                        2'd0: {n_b, n_c} = pw_val;
                        2'd1: {n_d, n_e} = pw_val;
                        2'd2: {n_h, n_l} = pw_val;
                        default: n_sp = pw_val;
                    endcase
                end
            end
            sm83_pkg::ST_WR2: begin
                mw_en   = 1'b1;
                mw_addr = r_wa + {{(ADDR_BITS-1){1'b0}}, 1'b1};
                mw_data = r_sp[15:8];
                n_state = sm83_pkg::ST_DONE;
            end
            sm83_pkg::ST_DONE: begin
                if (out_free) n_state = sm83_pkg::ST_IDLE;
            end
            default: n_state = sm83_pkg::ST_IDLE;
        endcase
    end

    // byte memory, registered read
    always_ff @(posedge i_clk) begin
        if (mw_en) r_mem[mw_addr] <= mw_data;
        r_mem_q <= r_mem[raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sm83_pkg::ST_IDLE;
            r_pc    <= 16'd0;
            r_sp    <= 16'd0;
            r_a     <= 8'd0;
            r_f     <= '0;
            r_b     <= 8'd0;
            r_c     <= 8'd0;
            r_d     <= 8'd0;
            r_e     <= 8'd0;
            r_h     <= 8'd0;
            r_l     <= 8'd0;
            r_halt  <= 1'b0;
            r_stop  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
            r_sp    <= n_sp;
            r_a     <= n_a;
            r_f     <= n_f;
            r_b     <= n_b;
            r_c     <= n_c;
            r_d     <= n_d;
            r_e     <= n_e;
            r_h     <= n_h;
            r_l     <= n_l;
            r_halt  <= n_halt;
            r_stop  <= n_stop;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cyc   <= n_cyc;
        r_unsup <= n_unsup;
        r_rd    <= n_rd;
        r_wa    <= n_wa;
        if (r_state == sm83_pkg::ST_OPC)  r_op <= r_mem_q;
        if (r_state == sm83_pkg::ST_IMM1) r_lo <= r_mem_q;
        if (r_state == sm83_pkg::ST_IMM2) r_hi <= r_mem_q;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == sm83_pkg::ST_DONE && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == sm83_pkg::ST_DONE && out_free) begin
            r_o_rd    <= r_rd;
            r_o_pc    <= r_pc;
            r_o_a     <= r_a;
            r_o_f     <= {r_f, 4'd0};
            r_o_bc    <= {r_b, r_c};
            r_o_de    <= {r_d, r_e};
            r_o_hl    <= hl;
            r_o_sp    <= r_sp;
            r_o_cyc   <= r_cyc;
            r_o_halt  <= r_halt;
            r_o_stop  <= r_stop;
            r_o_unsup <= r_unsup;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_read_data        = r_o_rd;
    assign o_pc_value         = r_o_pc;
    assign o_acc_value        = r_o_a;
    assign o_flag_value       = r_o_f;
    assign o_pair_bc          = r_o_bc;
    assign o_pair_de          = r_o_de;
    assign o_pair_hl          = r_o_hl;
    assign o_stack_value      = r_o_sp;
    assign o_cycle_count      = r_o_cyc;
    assign o_halted_mark      = r_o_halt;
    assign o_stopped_mark     = r_o_stop;
    assign o_unsupported_mark = r_o_unsup;

    `SM83_ASSERT_NXT(a_exec_fetch, i_clk, i_rst_n, in_acc && (i_operation == sm83_pkg::OPN_EXEC), r_state == sm83_pkg::ST_OPC, "execute word did not start opcode fetch")
    `SM83_ASSERT_IMP(a_wr2_after_exec, i_clk, i_rst_n, r_state == sm83_pkg::ST_WR2, $past(r_state) == sm83_pkg::ST_EXEC, "second store not preceded by execute")
    `SM83_ASSERT_NXT(a_done_loads, i_clk, i_rst_n, (r_state == sm83_pkg::ST_DONE) && !r_out_valid, r_out_valid && (r_state == sm83_pkg::ST_IDLE), "finished word not loaded into output register")

endmodule
`default_nettype wire

// ===== bench/sm83_exec_checker.sv =====
// checker for the sm83 execute core: predicts each result word and compares
module sm83_exec_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [1:0]  i_operation,
    input  logic [15:0] i_address,
    input  logic [7:0]  i_write_data,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [7:0]  i_read_data,
    input  logic [15:0] i_pc_value,
    input  logic [7:0]  i_acc_value,
    input  logic [7:0]  i_flag_value,
    input  logic [15:0] i_pair_bc,
    input  logic [15:0] i_pair_de,
    input  logic [15:0] i_pair_hl,
    input  logic [15:0] i_stack_value,
    input  logic [4:0]  i_cycle_count,
    input  logic        i_halted_mark,
    input  logic        i_stopped_mark,
    input  logic        i_unsupported_mark,
    output int          o_errors,
    output int          o_pending,
    output logic [15:0] o_pc,
    output logic [15:0] o_bc,
    output logic [15:0] o_de,
    output logic [15:0] o_hl
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0]  rd;
        logic [15:0] pc;
        logic [7:0]  acc;
        logic [7:0]  flg;
        logic [15:0] bc;
        logic [15:0] de;
        logic [15:0] hl;
        logic [15:0] sp;
        logic [4:0]  cyc;
        logic        hm;
        logic        sm;
        logic        um;
    } t_cpu_word;

    logic [7:0]  mem [0:65535];
    logic [7:0]  regs [0:5];
    logic [7:0]  acc;
    logic        fz, fn, fh, fc;
    logic [15:0] sp, pc;
    logic        halted, stopped;
    t_cpu_word   expected_words[$];
    int          errors;

    assign o_errors  = errors;
    assign o_pending = expected_words.size();
    assign o_pc = pc;
    assign o_bc = {regs[0], regs[1]};
    assign o_de = {regs[2], regs[3]};
    assign o_hl = {regs[4], regs[5]};

    function automatic logic [7:0] fetch_byte();
        logic [7:0] v;
        v = mem[pc];
        pc = pc + 16'd1;
        return v;
    endfunction

    function automatic logic [15:0] pair_of(logic [1:0] p);
        if (p == 2'd3) return sp;
        return {regs[p*2], regs[p*2+1]};
    endfunction

    function automatic void pair_put(logic [1:0] p, logic [15:0] v);
        if (p == 2'd3) sp = v;
        else begin
            regs[p*2] = v[15:8];
            regs[p*2+1] = v[7:0];
        end
    endfunction

    function automatic logic [7:0] r8_of(logic [2:0] i);
        if (i == sm83_pkg::R8_MEM) return mem[pair_of(2'd2)];
        if (i == sm83_pkg::R8_A) return acc;
        return regs[i];
    endfunction

    function automatic void r8_put(logic [2:0] i, logic [7:0] v);
        if (i == sm83_pkg::R8_MEM) mem[pair_of(2'd2)] = v;
        else if (i == sm83_pkg::R8_A) acc = v;
        else regs[i] = v;
    endfunction

    function automatic void alu_apply(logic [1:0] kind, logic [7:0] v);
        int a, b, c, r;
        a = acc;
        b = v;
        c = (kind[0] && fc) ? 1 : 0;
        if (kind < 2) begin
            r = a + b + c;
            fn = 1'b0;
            fh = (a % 16) + (b % 16) + c > 15;
            fc = r > 255;
        end else begin
            r = a - b - c;
            fn = 1'b1;
            fh = (a % 16) < (b % 16) + c;
            fc = a < b + c;
        end
        acc = r[7:0];
        fz = (acc == 8'd0);
    endfunction

    function automatic logic [4:0] rel_jump(logic take);
        logic [7:0] off;
        off = fetch_byte();
        if (!take) return 5'd8;
        pc = pc + {{8{off[7]}}, off};
        return 5'd12;
    endfunction

    function automatic logic [4:0] run_opcode(output logic uns);
        logic [7:0]  op, lo, hi, v;
        logic [2:0]  y, z;
        logic [1:0]  p;
        logic [15:0] a16;
        logic        co;
        int          h, w;
        op = fetch_byte();
        y = op[5:3];
        z = op[2:0];
        p = op[5:4];
        uns = 1'b0;
        if (op >= sm83_pkg::OP_UNS_LO || op == sm83_pkg::OP_DAA) begin
            if (op == sm83_pkg::PREFIX_OP) void'(fetch_byte());
            uns = 1'b1;
            return 5'd4;
        end
        if (op >= sm83_pkg::OP_ALU_LO) begin
            alu_apply(op[4:3], r8_of(z));
            return (z == sm83_pkg::R8_MEM) ? 5'd8 : 5'd4;
        end
        if (op >= sm83_pkg::OP_LD_LO) begin
            if (op == sm83_pkg::OP_HALT) begin
                halted = 1'b1;
                return 5'd4;
            end
            r8_put(y, r8_of(z));
            return (y == sm83_pkg::R8_MEM || z == sm83_pkg::R8_MEM) ? 5'd8 : 5'd4;
        end
        case (op)
            sm83_pkg::OP_NOP: return 5'd4;
            sm83_pkg::OP_RLCA, sm83_pkg::OP_RRCA, sm83_pkg::OP_RLA, sm83_pkg::OP_RRA: begin
                case (y[1:0])
                    2'd0: begin co = acc[7]; acc = {acc[6:0], co}; end
                    2'd1: begin co = acc[0]; acc = {co, acc[7:1]}; end
                    2'd2: begin co = acc[7]; acc = {acc[6:0], fc}; end
                    default: begin co = acc[0]; acc = {fc, acc[7:1]}; end
                endcase
                {fz, fn, fh, fc} = {3'b000, co};
                return 5'd4;
            end
            sm83_pkg::OP_LD_NN_SP: begin
                lo = fetch_byte();
                hi = fetch_byte();
                a16 = {hi, lo};
                mem[a16] = sp[7:0];
                mem[a16 + 16'd1] = sp[15:8];
                return 5'd20;
            end
            sm83_pkg::OP_STOP: begin
                stopped = 1'b1;
                return 5'd4;
            end
            sm83_pkg::OP_JR:    return rel_jump(1'b1);
            sm83_pkg::OP_JR_NZ: return rel_jump(!fz);
            sm83_pkg::OP_JR_Z:  return rel_jump(fz);
            sm83_pkg::OP_JR_NC: return rel_jump(!fc);
            sm83_pkg::OP_JR_C:  return rel_jump(fc);
            sm83_pkg::OP_CPL: begin
                acc = ~acc;
                fn = 1'b1;
                fh = 1'b1;
                return 5'd4;
            end
            sm83_pkg::OP_SCF: begin
                {fn, fh, fc} = 3'b001;
                return 5'd4;
            end
            sm83_pkg::OP_CCF: begin
                {fn, fh, fc} = {2'b00, !fc};
                return 5'd4;
            end
            default: ;
        endcase
        case (z)
            3'd4: begin
                v = r8_of(y);
                fh = (v[3:0] == 4'hF);
                v = v + 8'd1;
                fz = (v == 8'd0);
                fn = 1'b0;
                r8_put(y, v);
                return (y == sm83_pkg::R8_MEM) ? 5'd12 : 5'd4;
            end
            3'd5: begin
                v = r8_of(y);
                fh = (v[3:0] == 4'h0);
                v = v - 8'd1;
                fz = (v == 8'd0);
                fn = 1'b1;
                r8_put(y, v);
                return (y == sm83_pkg::R8_MEM) ? 5'd12 : 5'd4;
            end
            3'd6: begin
                r8_put(y, fetch_byte());
                return (y == sm83_pkg::R8_MEM) ? 5'd12 : 5'd8;
            end
            default: ;
        endcase
        case (op[3:0])
            4'h1: begin
                lo = fetch_byte();
                hi = fetch_byte();
                pair_put(p, {hi, lo});
                return 5'd12;
            end
            4'h2, 4'hA: begin
                a16 = (p < 2) ? pair_of(p) : pair_of(2'd2);
                if (op[3]) acc = mem[a16];
                else mem[a16] = acc;
                if (p == 2'd2) pair_put(2'd2, a16 + 16'd1);
                if (p == 2'd3) pair_put(2'd2, a16 - 16'd1);
                return 5'd8;
            end
            4'h3: begin
                pair_put(p, pair_of(p) + 16'd1);
                return 5'd8;
            end
            4'hB: begin
                pair_put(p, pair_of(p) - 16'd1);
                return 5'd8;
            end
            4'h9: begin
                h = pair_of(2'd2);
                w = pair_of(p);
                fn = 1'b0;
                fh = (h % 4096) + (w % 4096) > 4095;
                fc = h + w > 65535;
                pair_put(2'd2, 16'(h + w));
                return 5'd8;
            end
            default: ;
        endcase
        uns = 1'b1;
        return 5'd4;
    endfunction

    function automatic t_cpu_word predict_word(logic [1:0] opn, logic [15:0] ad,
                                               logic [7:0] wd);
        t_cpu_word r;
        logic      uns;
        r = '0;
        uns = 1'b0;
        if (opn == sm83_pkg::OPN_WRITE) mem[ad] = wd;
        else if (opn == sm83_pkg::OPN_READ) r.rd = mem[ad];
        else if (opn == sm83_pkg::OPN_EXEC) r.cyc = run_opcode(uns);
        r.pc = pc;
        r.acc = acc;
        r.flg = {fz, fn, fh, fc, 4'b0000};
        r.bc = pair_of(2'd0);
        r.de = pair_of(2'd1);
        r.hl = pair_of(2'd2);
        r.sp = sp;
        r.hm = halted;
        r.sm = stopped;
        r.um = uns;
        return r;
    endfunction

    function automatic void check_field(string nm, logic [15:0] e, logic [15:0] a);
        if (a !== e) begin
            errors++;
            $display("%0t mismatch %s: expected %h, actual %h", $realtime, nm, e, a);
        end
    endfunction

    always @(posedge i_clk) begin
        t_cpu_word e;
        if (!i_rst_n) begin
            for (int i = 0; i < 6; i++) regs[i] = 8'd0;
            acc = 8'd0;
            {fz, fn, fh, fc} = 4'b0000;
            sp = 16'd0;
            pc = 16'd0;
            halted = 1'b0;
            stopped = 1'b0;
            expected_words.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_words.size() == 0) begin
                    errors++;
                    $display("%0t result word with nothing expected", $realtime);
                end else begin
                    e = expected_words.pop_front();
                    check_field("read_data", e.rd, i_read_data);
                    check_field("pc_value", e.pc, i_pc_value);
                    check_field("acc_value", e.acc, i_acc_value);
                    check_field("flag_value", e.flg, i_flag_value);
                    check_field("pair_bc", e.bc, i_pair_bc);
                    check_field("pair_de", e.de, i_pair_de);
                    check_field("pair_hl", e.hl, i_pair_hl);
                    check_field("stack_value", e.sp, i_stack_value);
                    check_field("cycle_count", e.cyc, i_cycle_count);
                    check_field("halted_mark", e.hm, i_halted_mark);
                    check_field("stopped_mark", e.sm, i_stopped_mark);
                    check_field("unsupported_mark", e.um, i_unsupported_mark);
                end
            end
            if (i_in_valid && !i_in_stall)
                expected_words.push_back(predict_word(i_operation, i_address, i_write_data));
        end
    end

    initial errors = 0;
endmodule

// ===== bench/tb.sv =====
// testbench top for the sm83 execute core: stimulus, idling and verdict
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;

    logic        i_clk, i_rst_n, i_valid, o_stall, i_stall, o_valid;
    logic [1:0]  i_operation;
    logic [15:0] i_address;
    logic [7:0]  i_write_data;
    logic [7:0]  o_read_data, o_acc_value, o_flag_value;
    logic [15:0] o_pc_value, o_pair_bc, o_pair_de, o_pair_hl, o_stack_value;
    logic [4:0]  o_cycle_count;
    logic        o_halted_mark, o_stopped_mark, o_unsupported_mark;
    int          fail_count, pending;
    logic [15:0] pc_now, bc_now, de_now, hl_now;
    bit          written [0:65535];
    logic [15:0] written_list[$];
    bit          quiet;
    int          cycles;

    sm83_cpu_execute_core i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_operation(i_operation), .i_address(i_address), .i_write_data(i_write_data),
        .o_valid(o_valid), .i_stall(i_stall), .o_read_data(o_read_data),
        .o_pc_value(o_pc_value), .o_acc_value(o_acc_value), .o_flag_value(o_flag_value),
        .o_pair_bc(o_pair_bc), .o_pair_de(o_pair_de), .o_pair_hl(o_pair_hl),
        .o_stack_value(o_stack_value), .o_cycle_count(o_cycle_count),
        .o_halted_mark(o_halted_mark), .o_stopped_mark(o_stopped_mark),
        .o_unsupported_mark(o_unsupported_mark)
    );

    sm83_exec_checker i_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_valid), .i_in_stall(o_stall),
        .i_operation(i_operation), .i_address(i_address), .i_write_data(i_write_data),
        .i_out_valid(o_valid), .i_out_stall(i_stall), .i_read_data(o_read_data),
        .i_pc_value(o_pc_value), .i_acc_value(o_acc_value), .i_flag_value(o_flag_value),
        .i_pair_bc(o_pair_bc), .i_pair_de(o_pair_de), .i_pair_hl(o_pair_hl),
        .i_stack_value(o_stack_value), .i_cycle_count(o_cycle_count),
        .i_halted_mark(o_halted_mark), .i_stopped_mark(o_stopped_mark),
        .i_unsupported_mark(o_unsupported_mark), .o_errors(fail_count),
        .o_pending(pending), .o_pc(pc_now), .o_bc(bc_now), .o_de(de_now), .o_hl(hl_now)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("** sm83_cpu_execute_core: FAILED **");
            $finish;
        end
    end

    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!quiet && $urandom_range(0, 5) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 5)) @(negedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_word(logic [1:0] opn, logic [15:0] ad, logic [7:0] wd);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge i_clk);
        end
        i_operation  <= opn;
        i_address    <= ad;
        i_write_data <= wd;
        i_valid      <= 1'b1;
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
    endtask

    task automatic store(logic [15:0] ad, logic [7:0] wd);
        send_word(sm83_pkg::OPN_WRITE, ad, wd);
        if (!written[ad]) written_list.push_back(ad);
        written[ad] = 1'b1;
    endtask

    task automatic cover_ptr(logic [15:0] ad);
        if (!written[ad]) store(ad, 8'($urandom));
    endtask

    // lays the instruction down at pc and makes every byte it may read defined
    task automatic run_instr(logic [7:0] opc, logic [7:0] b1, logic [7:0] b2);
        logic [15:0] pc0;
        pc0 = pc_now;
        cover_ptr(hl_now);
        cover_ptr(bc_now);
        cover_ptr(de_now);
        store(pc0 + 16'd1, b1);
        store(pc0 + 16'd2, b2);
        store(pc0, opc);
        send_word(sm83_pkg::OPN_EXEC, 16'($urandom), 8'($urandom));
    endtask

    function automatic logic [7:0] pick_opcode();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return 8'($urandom_range(0, 8'h9F));
        if (r < 83) return sm83_pkg::PREFIX_OP;
        if (r < 85) return sm83_pkg::OP_DAA;
        if (r < 87) return sm83_pkg::OP_HALT;
        if (r < 89) return sm83_pkg::OP_STOP;
        return 8'($urandom_range(sm83_pkg::OP_UNS_LO, 8'hFF));
    endfunction

    initial begin
        int sel;
        i_valid = 1'b0;
        i_operation = sm83_pkg::OPN_WRITE;
        i_address = 16'd0;
        i_write_data = 8'd0;
        i_rst_n = 1'b0;
        quiet = 1'b0;
        cycles = 0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        store(16'h0000, 8'h00);
        store(16'hFFFF, 8'hFF);
        send_word(sm83_pkg::OPN_READ, 16'hFFFF, 8'h00);
        send_word(sm83_pkg::OPN_READ, 16'h0000, 8'hFF);
        send_word(sm83_pkg::OPN_NONE, 16'hFFFF, 8'hFF);
        run_instr(8'h3E, 8'hFF, 8'h00);
        run_instr(8'h87, 8'h00, 8'h00);
        run_instr(8'h8F, 8'h00, 8'h00);
        run_instr(8'h97, 8'h00, 8'h00);
        run_instr(8'h9F, 8'h00, 8'h00);
        run_instr(8'h3C, 8'h00, 8'h00);
        run_instr(sm83_pkg::OP_RLCA, 8'h00, 8'h00);
        run_instr(sm83_pkg::OP_RRA, 8'h00, 8'h00);
        run_instr(sm83_pkg::OP_CPL, 8'h00, 8'h00);
        run_instr(sm83_pkg::OP_SCF, 8'h00, 8'h00);
        run_instr(sm83_pkg::OP_CCF, 8'h00, 8'h00);
        run_instr(sm83_pkg::OP_JR, 8'h80, 8'h00);
        run_instr(sm83_pkg::OP_JR_NZ, 8'h7F, 8'h00);
        run_instr(8'h31, 8'hFF, 8'hFF);
        run_instr(sm83_pkg::OP_LD_NN_SP, 8'hFF, 8'hFF);
        run_instr(8'h21, 8'hFF, 8'hFF);
        run_instr(8'h23, 8'h00, 8'h00);
        run_instr(8'h09, 8'h00, 8'h00);
        run_instr(8'h34, 8'h00, 8'h00);
        run_instr(sm83_pkg::OP_HALT, 8'h00, 8'h00);
        run_instr(sm83_pkg::OP_STOP, 8'h00, 8'h00);
        run_instr(sm83_pkg::PREFIX_OP, 8'h37, 8'h00);
        run_instr(sm83_pkg::OP_DAA, 8'h00, 8'h00);

        for (int n = 0; n < 240; n++) begin
            if (n >= 200) quiet = 1'b1;
            sel = $urandom_range(0, 99);
            if (sel < 70)
                run_instr(pick_opcode(), 8'($urandom), 8'($urandom));
            else if (sel < 85)
                send_word(sm83_pkg::OPN_READ,
                          written_list[$urandom_range(0, written_list.size() - 1)],
                          8'($urandom));
            else if (sel < 95)
                store(16'($urandom), 8'($urandom));
            else
                send_word(sm83_pkg::OPN_NONE, 16'($urandom), 8'($urandom));
        end
        i_valid <= 1'b0;

        while (pending != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        if (fail_count == 0)
            $display("** sm83_cpu_execute_core: PASSED **");
        else
            $display("** sm83_cpu_execute_core: FAILED **");
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+design
design/sm83_pkg.sv
design/sm83_alu.sv
design/sm83_cpu_execute_core.sv
bench/sm83_exec_checker.sv
bench/tb.sv
